### sv/fqd_pkg.sv
// Package: shared types and codes for the deduplicating FIFO queue.
`default_nettype none

package fqd_pkg;

   typedef enum logic [1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_PEEK    = 2'd2,
      CMD_UNIQUE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_UNDER = 2'd1,
      STAT_OVER  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_WAIT,
      S_UQ_RD,
      S_UQ_CMP,
      S_FINISH
   } state_type;

   typedef struct packed {
      cmd_type            command;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [3:0]         removed_count;
      logic [4:0]         occupancy;
      logic               is_empty;
      status_type         status;
   } rsp_type;

endpackage

`default_nettype wire

### sv/fifo_queue_with_dedup_top.sv
// Top level: circular-buffer FIFO with enqueue, dequeue, peek and make-unique.
//
//   channel  direction  handshake                  payload
//   req      in         req_valid / req_stall      req_data  (req_type)
//   rsp      out        rsp_valid / rsp_stall      rsp_data  (rsp_type)
//
// Enqueue and failed commands go from idle straight to the finish state; dequeue
// and peek pass through a read-wait state first. Make unique does one memory read
// and one compare-and-write per held word through the word store (one read port, one write port).
// Reset clears head and count; the word store itself is never cleared.
// A new request transfers whenever the sequencer is idle, even while a result
// still waits on rsp_stall; the sequencer then holds in its final state.
`default_nettype none

module fifo_queue_with_dedup_top
   import fqd_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                          input logic [CW-1:0] off);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(off);
      if (s >= (CW+1)'(DEPTH)) begin
         s = s - (CW+1)'(DEPTH);
      end
      return AW'(s);
   endfunction

   logic [31:0]        mem [DEPTH];
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [AW-1:0]      mem_raddr;
   logic [31:0]        mem_wdata;
   logic [31:0]        rdata_ff;

   state_type          state_ff, state_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   cmd_type            cmd_ff, cmd_in;
   logic [31:0]        target_ff, target_in;
   logic [CW-1:0]      rd_ff, rd_in;
   logic [CW-1:0]      wr_ff, wr_in;
   logic               seen_ff, seen_in;
   rsp_type            res_ff, res_in;
   rsp_type            out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic               req_xfer;
   logic               rsp_xfer;
   logic               load;
   logic               match;
   logic [CW-1:0]      wr_next;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign match     = (rdata_ff == target_ff);
   assign load      = (state_ff == S_FINISH) && !(out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      target_in    = target_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      seen_in      = seen_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_xfer;
      mem_we       = 1'b0;
      mem_waddr    = slot(head_ff, wr_ff);
      mem_wdata    = rdata_ff;
      mem_raddr    = head_ff;
      wr_next      = wr_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cmd_in               = req_data.command;
               target_in            = req_data.value;
               rd_in                = '0;
               wr_in                = '0;
               seen_in              = 1'b0;
               res_in.read_value    = '0;
               res_in.removed_count = '0;
               res_in.status        = STAT_OK;
               res_in.occupancy     = 5'(count_ff);
               res_in.is_empty      = (count_ff == '0);
               state_in             = S_FINISH;
               case (req_data.command)
                  CMD_ENQUEUE: begin
                     if (count_ff == CW'(DEPTH)) begin
                        res_in.status = STAT_OVER;
                     end else begin
                        mem_we           = 1'b1;
                        mem_waddr        = slot(head_ff, count_ff);
                        mem_wdata        = req_data.value;
                        count_in         = count_ff + CW'(1);
                        res_in.occupancy = 5'(count_ff + CW'(1));
                        res_in.is_empty  = 1'b0;
                     end
                  end
                  CMD_DEQUEUE, CMD_PEEK: begin
                     if (count_ff == '0) begin
                        res_in.status = STAT_UNDER;
                     end else begin
                        state_in = S_RD_WAIT;
                     end
                  end
                  default: begin
                     if (count_ff != '0) begin
                        state_in = S_UQ_RD;
                     end
                  end
               endcase
            end
         end
         S_RD_WAIT: begin
            res_in.read_value = rdata_ff;
            if (cmd_ff == CMD_DEQUEUE) begin
               head_in          = slot(head_ff, CW'(1));
               count_in         = count_ff - CW'(1);
               res_in.occupancy = 5'(count_ff - CW'(1));
               res_in.is_empty  = (count_ff == CW'(1));
            end
            state_in = S_FINISH;
         end
         S_UQ_RD: begin
            mem_raddr = slot(head_ff, rd_ff);
            state_in  = S_UQ_CMP;
         end
         S_UQ_CMP: begin
            if (!(match && seen_ff)) begin
               mem_we  = 1'b1;
               wr_next = wr_ff + CW'(1);
            end
            if (match) begin
               seen_in = 1'b1;
            end
            wr_in = wr_next;
            rd_in = rd_ff + CW'(1);
            if (rd_ff + CW'(1) == count_ff) begin
               count_in             = wr_next;
               res_in.removed_count = 4'(count_ff - wr_next);
               res_in.occupancy     = 5'(wr_next);
               res_in.is_empty      = (wr_next == '0);
               state_in             = S_FINISH;
            end else begin
               state_in = S_UQ_RD;
            end
         end
         S_FINISH: begin
            if (load) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         seen_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         seen_ff      <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      target_ff <= target_in;
      rd_ff     <= rd_in;
      wr_ff     <= wr_in;
      res_ff    <= res_in;
      out_ff    <= out_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("word count above depth");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UQ_CMP) |-> (wr_ff <= rd_ff && rd_ff < count_ff))
      else $error("compaction write pointer passed read pointer");

   a_finish_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && !(out_valid_ff && rsp_stall)) |=>
         (out_valid_ff && state_ff == S_IDLE))
      else $error("finished result not presented");

   a_unique_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UQ_CMP) |=> (count_ff <= $past(count_ff)))
      else $error("make unique grew the queue");

endmodule

`default_nettype wire

### verif/fifo_queue_with_dedup_top_test.sv
// Testbench: directed table then random command mix, checked against a FIFO-with-dedup predictor.
module fifo_queue_with_dedup_top_test;
   import fqd_pkg::*;

   localparam int DEPTH        = 16;
   localparam int RANDOM_ITEMS = 1600;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      cmd_type     command;
      logic [31:0] value;
      int          reps;
      bit          lit_on;
      rsp_type     lit;
   } step_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   bit      item_lit_on;
   rsp_type item_lit;
   int      req_idle_pct;
   int      rsp_idle_pct;

   logic [31:0]  held_words [DEPTH];
   int           front_slot;
   int           held_count;
   rsp_type      awaited_replies [$];
   int           mismatch_count;
   int           quiet_cycles;
   step_row_type directed_rows [12];

   fifo_queue_with_dedup_top #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   function automatic rsp_type reply(logic [31:0] rv, logic [4:0] occ, status_type st);
      rsp_type r;
      r.read_value    = rv;
      r.removed_count = 4'd0;
      r.occupancy     = occ;
      r.is_empty      = (occ == 5'd0);
      r.status        = st;
      return r;
   endfunction

   function automatic rsp_type apply_command(req_type cmd);
      rsp_type     r;
      int          kept;
      bit          seen;
      logic [31:0] w;
      r        = '0;
      r.status = STAT_OK;
      case (cmd.command)
         CMD_ENQUEUE: begin
            if (held_count >= DEPTH) begin
               r.status = STAT_OVER;
            end else begin
               held_words[(front_slot + held_count) % DEPTH] = cmd.value;
               held_count++;
            end
         end
         CMD_DEQUEUE: begin
            if (held_count == 0) begin
               r.status = STAT_UNDER;
            end else begin
               r.read_value = held_words[front_slot];
               front_slot   = (front_slot + 1) % DEPTH;
               held_count--;
            end
         end
         CMD_PEEK: begin
            if (held_count == 0) begin
               r.status = STAT_UNDER;
            end else begin
               r.read_value = held_words[front_slot];
            end
         end
         CMD_UNIQUE: begin
            kept = 0;
            seen = 1'b0;
            for (int rd = 0; rd < held_count; rd++) begin
               w = held_words[(front_slot + rd) % DEPTH];
               if (w == cmd.value) begin
                  if (seen) continue;
                  seen = 1'b1;
               end
               held_words[(front_slot + kept) % DEPTH] = w;
               kept++;
            end
            r.removed_count = 4'(held_count - kept);
            held_count      = kept;
         end
         default: begin
         end
      endcase
      r.occupancy = 5'(held_count);
      r.is_empty  = (held_count == 0);
      return r;
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      bit      moved;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (req_valid && !req_stall) begin
            want = apply_command(req_data);
            if (item_lit_on) want = item_lit;
            awaited_replies.push_back(want);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (awaited_replies.size() == 0) begin
               $error("unexpected transfer on rsp: %p", rsp_data);
               mismatch_count++;
            end else begin
               want = awaited_replies.pop_front();
               compare_field("read_value", want.read_value, rsp_data.read_value);
               compare_field("removed_count", want.removed_count, rsp_data.removed_count);
               compare_field("occupancy", want.occupancy, rsp_data.occupancy);
               compare_field("is_empty", want.is_empty, rsp_data.is_empty);
               compare_field("status", want.status, rsp_data.status);
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("fifo_queue_with_dedup_top_test: errors");
            $finish;
         end
      end
   end

   task automatic send_item(req_type item, bit lit_on, rsp_type lit);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_data    <= item;
      item_lit_on <= lit_on;
      item_lit    <= lit;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   initial begin
      req_type     item;
      int          mode_left;
      bit          filling;
      int          r;
      logic [31:0] value_pool [4];

      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      item_lit_on    = 1'b0;
      item_lit       = '0;
      req_idle_pct   = 18;
      rsp_idle_pct   = 78;
      mismatch_count = 0;
      quiet_cycles   = 0;
      front_slot     = 0;
      held_count     = 0;
      mode_left      = 0;
      filling        = 1'b0;

      directed_rows = '{
         '{CMD_DEQUEUE, 32'h0000_0000,  1, 1'b1, reply(32'h0, 5'd0, STAT_UNDER)},
         '{CMD_PEEK,    32'h0000_0000,  1, 1'b1, reply(32'h0, 5'd0, STAT_UNDER)},
         '{CMD_UNIQUE,  32'h0000_0000,  1, 1'b1, reply(32'h0, 5'd0, STAT_OK)},
         '{CMD_ENQUEUE, 32'h7FFF_FFFF,  1, 1'b1, reply(32'h0, 5'd1, STAT_OK)},
         '{CMD_PEEK,    32'h0000_0000,  1, 1'b1, reply(32'h7FFF_FFFF, 5'd1, STAT_OK)},
         '{CMD_DEQUEUE, 32'h0000_0000,  1, 1'b1, reply(32'h7FFF_FFFF, 5'd0, STAT_OK)},
         '{CMD_ENQUEUE, 32'h8000_0000, 16, 1'b0, '0},
         '{CMD_ENQUEUE, 32'hFFFF_FFFF,  1, 1'b1, reply(32'h0, 5'd16, STAT_OVER)},
         '{CMD_UNIQUE,  32'h8000_0000,  1, 1'b0, '0},
         '{CMD_UNIQUE,  32'h8000_0000,  1, 1'b0, '0},
         '{CMD_PEEK,    32'hFFFF_FFFF,  1, 1'b0, '0},
         '{CMD_DEQUEUE, 32'h0000_0000,  1, 1'b0, '0}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         repeat (directed_rows[i].reps) begin
            item.command = directed_rows[i].command;
            item.value   = directed_rows[i].value;
            send_item(item, directed_rows[i].lit_on, directed_rows[i].lit);
         end
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            req_idle_pct <= 78;
            rsp_idle_pct <= 18;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            req_idle_pct <= 0;
            rsp_idle_pct <= 0;
         end
         if (n % 200 == 0) begin
            foreach (value_pool[k]) value_pool[k] = $urandom;
         end
         if (mode_left == 0) begin
            filling   = !filling;
            mode_left = $urandom_range(20, 60);
         end
         mode_left--;
         r = $urandom_range(99);
         if (filling) begin
            item.command = (r < 62) ? CMD_ENQUEUE : (r < 80) ? CMD_DEQUEUE :
                           (r < 88) ? CMD_PEEK : CMD_UNIQUE;
         end else begin
            item.command = (r < 20) ? CMD_ENQUEUE : (r < 68) ? CMD_DEQUEUE :
                           (r < 83) ? CMD_PEEK : CMD_UNIQUE;
         end
         item.value = ($urandom_range(99) < 70) ? value_pool[$urandom_range(3)] : $urandom;
         send_item(item, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (awaited_replies.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("fifo_queue_with_dedup_top_test: clean");
      end else begin
         $display("fifo_queue_with_dedup_top_test: errors");
      end
      $finish;
   end

endmodule
